FILE: rtl/ttsi_pkg.sv
// ----------------------------------------------------------------------------
// ttsi_pkg
// Shared constants, codes and character helpers for the text to signed
// integer converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttsi_pkg;

  localparam int VALUE_BITS_DEF  = 64;
  localparam int OFFSET_BITS_DEF = 16;

  localparam int CH_W     = 8;
  localparam int BASE_W   = 6;
  localparam int STATUS_W = 2;

  localparam int APB_DW = 32;
  localparam int APB_AW = 2;

  localparam logic [APB_AW-1:0] ADDR_NUMBER_BASE = 2'd0;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  localparam logic [BASE_W-1:0] DIGIT_NONE = 6'd63;

  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7a;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5a;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_X     = 8'h78;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CH_W-1:0] CH_TEN   = 8'd10;

  function automatic logic [BASE_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [BASE_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      d = BASE_W'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = BASE_W'(c - CH_LA + CH_TEN);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = BASE_W'(c - CH_UA + CH_TEN);
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ttsi_in_if.sv
// ----------------------------------------------------------------------------
// ttsi_in_if
// Character channel: one byte of text and a start-of-string flag per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ttsi_in_if import ttsi_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            first;

  modport source (output valid, output ch, output first, input ready);
  modport sink   (input valid, input ch, input first, output ready);
endinterface

`default_nettype wire

FILE: rtl/ttsi_out_if.sv
// ----------------------------------------------------------------------------
// ttsi_out_if
// Result channel: converted value, consumed offset and status per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ttsi_out_if import ttsi_pkg::*;
  #(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
  );
  logic                        valid;
  logic                        ready;
  logic signed [VALUE_BITS-1:0] value;
  logic [OFFSET_BITS-1:0]      end_offset;
  logic [STATUS_W-1:0]         status;

  modport source (output valid, output value, output end_offset, output status, input ready);
  modport sink   (input valid, input value, input end_offset, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/text_to_signed_integer.sv
// ----------------------------------------------------------------------------
// text_to_signed_integer
// Streaming strtol-style converter: one character per beat in, one result
// beat per finished string out.
// ----------------------------------------------------------------------------
// Characters are taken one per clock into an input register; then a single
// multiply-add by the active radix (VALUE_BITS x 6 bits) with an exact range
// compare updates the conversion state and, at the stopping character, loads
// the result register. A result is valid once the beat ending the string has
// passed the input and then the result register; a new character may be
// accepted every cycle as long as the result side keeps taking beats. The
// radix is sampled from number_base at the character flagged first; write it
// only while the converter is idle. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module text_to_signed_integer import ttsi_pkg::*;
  #(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
  )
  (
    input  wire                 clk,
    input  wire                 rst_n,
    ttsi_in_if.sink             in_beat,
    ttsi_out_if.source          out_beat,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [APB_AW-1:0]    paddr,
    input  wire [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
  );

  localparam int VB = VALUE_BITS;
  localparam int OB = OFFSET_BITS;
  localparam int PW = VALUE_BITS + BASE_W;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_SIGN   = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_ZEROX  = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  localparam logic [VB-1:0] LIM_POS = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] LIM_NEG = {1'b1, {(VB-1){1'b0}}};

  function automatic logic [OB-1:0] sat_inc(input logic [OB-1:0] v);
    return (v == {OB{1'b1}}) ? v : OB'(v + 1'b1);
  endfunction

  logic [BASE_W-1:0] number_base_r;

  logic              in_vld_r;
  logic [CH_W-1:0]   ch_r;
  logic              first_r;

  logic [2:0]        phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [VB-1:0]     acc_r, acc_nxt;
  logic [OB-1:0]     cnt_r, cnt_nxt;
  logic              hit_r, hit_nxt;

  logic              out_vld_r;
  logic [VB-1:0]     out_val_r, out_val_nxt;
  logic [OB-1:0]     out_off_r;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;

  logic              emit;
  logic              after_sgn;
  logic              dig;
  logic [BASE_W-1:0] d;
  logic [PW-1:0]     prod;
  logic [VB-1:0]     lim;
  logic              proc;
  logic              cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign prdata = APB_DW'(number_base_r);
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_NUMBER_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_RESET;
    end else if (cfg_wr) begin
      number_base_r <= pwdata[BASE_W-1:0];
    end
  end

  // input register
  assign proc          = in_vld_r && (!out_vld_r || out_beat.ready);
  assign in_beat.ready = !in_vld_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_beat.valid && in_beat.ready) begin
      in_vld_r <= 1'b1;
    end else if (proc) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat.valid && in_beat.ready) begin
      ch_r    <= in_beat.ch;
      first_r <= in_beat.first;
    end
  end

  // character step
  assign d = digit_of(ch_r);

  always_comb begin
    phase_nxt   = phase_r;
    neg_nxt     = neg_r;
    base_nxt    = base_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    hit_nxt     = hit_r;
    emit        = 1'b0;
    after_sgn   = 1'b0;
    dig         = 1'b0;
    out_val_nxt = '0;
    out_st_nxt  = ST_OK;
    prod        = '0;
    lim         = LIM_POS;

    if (first_r) begin
      neg_nxt  = 1'b0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      hit_nxt  = 1'b0;
      base_nxt = number_base_r;
      if (number_base_r == BASE_ONE || number_base_r > BASE_MAX) begin
        base_nxt   = BASE_AUTO;
        emit       = 1'b1;
        out_st_nxt = ST_BAD_BASE;
        phase_nxt  = PH_IDLE;
      end else begin
        phase_nxt = PH_LEAD;
      end
    end

    if (!emit) begin
      case (phase_nxt)
        PH_LEAD: begin
          if (is_space(ch_r)) begin
            cnt_nxt = sat_inc(cnt_nxt);
          end else if (ch_r == CH_MINUS) begin
            neg_nxt   = 1'b1;
            cnt_nxt   = sat_inc(cnt_nxt);
            phase_nxt = PH_SIGN;
          end else begin
            after_sgn = 1'b1;
          end
        end
        PH_SIGN: begin
          after_sgn = 1'b1;
        end
        PH_ZERO: begin
          if (ch_r == CH_X) begin
            phase_nxt = PH_ZEROX;
          end else begin
            if (base_nxt == BASE_AUTO) begin
              base_nxt = (d < BASE_MAX) ? BASE_OCT : BASE_DEC;
            end
            dig = 1'b1;
          end
        end
        PH_ZEROX: begin
          if (d < BASE_MAX) begin
            base_nxt = BASE_HEX;
            cnt_nxt  = sat_inc(cnt_nxt);
            dig      = 1'b1;
          end else begin
            emit      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_DIGITS: begin
          dig = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (after_sgn) begin
      if (ch_r == CH_0 && (base_nxt == BASE_AUTO || base_nxt == BASE_HEX)) begin
        cnt_nxt   = sat_inc(cnt_nxt);
        phase_nxt = PH_ZERO;
      end else begin
        if (base_nxt == BASE_AUTO) begin
          base_nxt = BASE_DEC;
        end
        dig = 1'b1;
      end
    end

    if (dig) begin
      lim  = neg_nxt ? LIM_NEG : LIM_POS;
      prod = PW'(acc_nxt) * PW'(base_nxt) + PW'(d);
      if (base_nxt < BASE_MIN || base_nxt > BASE_MAX || d >= base_nxt) begin
        emit        = 1'b1;
        out_val_nxt = neg_nxt ? VB'({VB{1'b0}} - acc_nxt) : acc_nxt;
        out_st_nxt  = hit_nxt ? ST_RANGE : ST_OK;
        phase_nxt   = PH_IDLE;
      end else begin
        if (!hit_nxt) begin
          if (prod > PW'(lim)) begin
            hit_nxt = 1'b1;
            acc_nxt = lim;
          end else begin
            acc_nxt = prod[VB-1:0];
          end
        end
        cnt_nxt   = sat_inc(cnt_nxt);
        phase_nxt = PH_DIGITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      neg_r   <= 1'b0;
      base_r  <= BASE_AUTO;
      acc_r   <= '0;
      cnt_r   <= '0;
      hit_r   <= 1'b0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      base_r  <= base_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_val_r <= out_val_nxt;
      out_off_r <= cnt_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  assign out_beat.valid      = out_vld_r;
  assign out_beat.value      = out_val_r;
  assign out_beat.end_offset = out_off_r;
  assign out_beat.status     = out_st_r;

  // checks
  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && emit) |=> (phase_r == PH_IDLE))
    else $error("phase not idle after result beat");

  a_saturated_acc: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> ((neg_r && acc_r == LIM_NEG) || (!neg_r && acc_r == LIM_POS)))
    else $error("range hit without saturated accumulator");

  a_digit_base: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIGITS) |-> (base_r >= BASE_MIN && base_r <= BASE_MAX))
    else $error("digits phase with unusable radix");

  a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_st_r == ST_BAD_BASE) |-> (out_val_r == '0 && out_off_r == '0))
    else $error("invalid radix beat carries data");

  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_beat.ready) |-> !proc)
    else $error("step taken while result stalled");

endmodule

`default_nettype wire

FILE: tb/text_to_signed_integer_test.sv
// ----------------------------------------------------------------------------
// text_to_signed_integer_test
// Drives character beats into the converter at several radix settings and
// predicts every result with a cycle-free model of the parse. Each result
// beat is compared field by field with the oldest prediction. The sequence
// is directed cases, then mostly well-formed numbers with noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_to_signed_integer_test;
  import ttsi_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE, P_LEAD, P_SIGN, P_ZERO, P_ZEROX, P_DIGITS
  } parse_phase_t;

  typedef struct {
    logic signed [VALUE_BITS_DEF-1:0] value;
    logic [OFFSET_BITS_DEF-1:0]       end_offset;
    logic [STATUS_W-1:0]              status;
  } conv_result_t;

  localparam logic [VALUE_BITS_DEF-1:0] POS_LIMIT = {1'b0, {(VALUE_BITS_DEF-1){1'b1}}};
  localparam logic [VALUE_BITS_DEF-1:0] NEG_LIMIT = {1'b1, {(VALUE_BITS_DEF-1){1'b0}}};
  localparam logic [OFFSET_BITS_DEF-1:0] OFFSET_TOP = '1;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [CH_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TOP   = 8'hff;
  localparam int RANDOM_CHARS = 1000;
  localparam int CHARS_PER_PHASE = 80;

  logic clk = 1'b0;
  logic rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  ttsi_in_if  u_in_if ();
  ttsi_out_if u_out_if ();

  text_to_signed_integer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (u_in_if),
    .out_beat (u_out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  conv_result_t pending_results [$];
  int           error_count = 0;
  int           chars_sent = 0;
  bit           quiet = 1'b0;

  logic [BASE_W-1:0]         base_reg  = BASE_RESET;
  parse_phase_t              ph        = P_IDLE;
  bit                        neg       = 1'b0;
  logic [BASE_W-1:0]         cur_base  = BASE_AUTO;
  logic [VALUE_BITS_DEF-1:0] mag       = '0;
  logic [OFFSET_BITS_DEF-1:0] used     = '0;
  bit                        sat       = 1'b0;

  function automatic logic [BASE_W-1:0] digit_value(input logic [CH_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) return BASE_W'(c - CH_0);
    if (c >= CH_LA && c <= CH_LZ) return BASE_W'(c - CH_LA + CH_TEN);
    if (c >= CH_UA && c <= CH_UZ) return BASE_W'(c - CH_UA + CH_TEN);
    return DIGIT_NONE;
  endfunction

  function automatic bit is_alnum(input logic [CH_W-1:0] c);
    return digit_value(c) < BASE_MAX;
  endfunction

  function automatic bit is_blank(input logic [CH_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic bump_count();
    if (used != OFFSET_TOP) used++;
  endtask

  task automatic post_result(input logic [VALUE_BITS_DEF-1:0] v,
                             input logic [STATUS_W-1:0] st);
    conv_result_t r;
    r.value      = v;
    r.end_offset = used;
    r.status     = st;
    pending_results.push_back(r);
    ph = P_IDLE;
  endtask

  task automatic take_digit(input logic [CH_W-1:0] c);
    logic [BASE_W-1:0]         d;
    logic [VALUE_BITS_DEF-1:0] lim;
    d   = digit_value(c);
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    if (cur_base < BASE_MIN || cur_base > BASE_MAX || d >= cur_base) begin
      post_result(neg ? (VALUE_BITS_DEF'(0) - mag) : mag, sat ? ST_RANGE : ST_OK);
    end else begin
      if (!sat) begin
        if (mag > (lim - VALUE_BITS_DEF'(d)) / VALUE_BITS_DEF'(cur_base)) begin
          sat = 1'b1;
          mag = lim;
        end else begin
          mag = mag * VALUE_BITS_DEF'(cur_base) + VALUE_BITS_DEF'(d);
        end
      end
      bump_count();
      ph = P_DIGITS;
    end
  endtask

  task automatic after_sign(input logic [CH_W-1:0] c);
    if (c == CH_0 && (cur_base == BASE_AUTO || cur_base == BASE_HEX)) begin
      bump_count();
      ph = P_ZERO;
    end else begin
      if (cur_base == BASE_AUTO) cur_base = BASE_DEC;
      take_digit(c);
    end
  endtask

  task automatic convert_char(input logic [CH_W-1:0] c, input bit first_flag);
    if (first_flag) begin
      neg      = 1'b0;
      mag      = '0;
      used     = '0;
      sat      = 1'b0;
      cur_base = base_reg;
      if (cur_base == BASE_ONE || cur_base > BASE_MAX) begin
        cur_base = BASE_AUTO;
        post_result('0, ST_BAD_BASE);
      end else begin
        ph = P_LEAD;
      end
    end
    case (ph)
      P_LEAD: begin
        if (is_blank(c)) begin
          bump_count();
        end else if (c == CH_MINUS) begin
          neg = 1'b1;
          bump_count();
          ph = P_SIGN;
        end else begin
          after_sign(c);
        end
      end
      P_SIGN: after_sign(c);
      P_ZERO: begin
        if (c == CH_X) begin
          ph = P_ZEROX;
        end else begin
          if (cur_base == BASE_AUTO) cur_base = is_alnum(c) ? BASE_OCT : BASE_DEC;
          take_digit(c);
        end
      end
      P_ZEROX: begin
        if (is_alnum(c)) begin
          cur_base = BASE_HEX;
          bump_count();
          take_digit(c);
        end else begin
          post_result('0, ST_OK);
        end
      end
      P_DIGITS: take_digit(c);
      default: ;
    endcase
  endtask

  task automatic send_char(input logic [CH_W-1:0] c, input bit first_flag);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      u_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    u_in_if.valid <= 1'b1;
    u_in_if.ch    <= c;
    u_in_if.first <= first_flag;
    @(posedge clk);
    while (!u_in_if.ready) @(posedge clk);
    chars_sent++;
    convert_char(c, first_flag);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  task automatic drain_results();
    u_in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_base(input logic [BASE_W-1:0] b);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NUMBER_BASE;
    pwdata  <= APB_DW'(b);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    base_reg = b;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DW'(b)) begin
      error_count++;
      $display("%0t: number_base read expected %0d got %0d", $time, b, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_string();
    logic [CH_W-1:0]           txt [$];
    logic [CH_W-1:0]           num [$];
    logic [BASE_W-1:0]         eff;
    logic [VALUE_BITS_DEF-1:0] m;
    logic [VALUE_BITS_DEF-1:0] dv;
    int kind;
    int trail;
    kind  = $urandom_range(0, 9);
    trail = 0;
    if (kind >= 8) begin
      repeat ($urandom_range(1, 6)) txt.push_back(CH_W'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3))
          txt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB + CH_W'($urandom_range(0, 4)));
      end
      if ($urandom_range(0, 1)) txt.push_back(CH_MINUS);
      eff = (base_reg == BASE_ONE || base_reg > BASE_MAX) ? BASE_DEC : base_reg;
      if (base_reg == BASE_AUTO) begin
        case ($urandom_range(0, 2))
          0: begin
            txt.push_back(CH_0);
            txt.push_back(CH_X);
            eff = BASE_HEX;
          end
          1: begin
            txt.push_back(CH_0);
            eff = BASE_OCT;
          end
          default: eff = BASE_DEC;
        endcase
      end else if (base_reg == BASE_HEX && $urandom_range(0, 1)) begin
        txt.push_back(CH_0);
        txt.push_back(CH_X);
      end
      case ($urandom_range(0, 7))
        0: m = POS_LIMIT;
        1: m = NEG_LIMIT;
        2: m = NEG_LIMIT + VALUE_BITS_DEF'($urandom_range(1, 3));
        3: m = {$urandom, $urandom};
        4: m = '0;
        default: m = VALUE_BITS_DEF'($urandom_range(0, 5000));
      endcase
      if (m == 0) num.push_front(CH_0);
      while (m != 0) begin
        dv = m % VALUE_BITS_DEF'(eff);
        m  = m / VALUE_BITS_DEF'(eff);
        if (dv < CH_TEN) num.push_front(CH_0 + CH_W'(dv));
        else num.push_front(($urandom_range(0, 1) ? CH_LA : CH_UA) + CH_W'(dv) - CH_TEN);
      end
      txt = {txt, num};
      if (kind != 7) begin
        case ($urandom_range(0, 5))
          0: txt.push_back(CH_SPACE);
          1: txt.push_back(CH_COMMA);
          2: txt.push_back(CH_NUL);
          3: txt.push_back(CH_W'($urandom_range(128, 255)));
          4: txt.push_back(CH_LZ);
          default: txt.push_back(CH_W'($urandom_range(0, 255)));
        endcase
      end
      if (kind == 6) trail = $urandom_range(1, 3);
    end
    foreach (txt[i]) send_char(txt[i], i == 0);
    repeat (trail) send_char(CH_W'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic test_reset_base_decimal();
    send_char(CH_TOP, 1'b0);
    send_text("7");
    send_char(CH_NUL, 1'b0);
    send_text("9");
    send_text(" -");
    send_char(CH_BANG, 1'b0);
    send_text("+5");
  endtask

  task automatic test_auto_base_prefixes();
    set_base(BASE_AUTO);
    send_text("0x:");
    send_text("0xg");
    send_text("017 ");
    send_text("0x1F.");
  endtask

  task automatic test_invalid_base();
    set_base(BASE_ONE);
    send_text("5");
  endtask

  task automatic test_negative_overflow();
    set_base(BASE_MAX);
    send_text("-zzzzzzzzzzzzz ");
  endtask

  task automatic test_random_mix();
    logic [BASE_W-1:0] plan [7];
    int phase_idx;
    int phase_end;
    plan = '{BASE_MIN, BASE_MAX, BASE_AUTO, BASE_HEX, BASE_OCT, BASE_DEC, BASE_ONE};
    phase_idx = 0;
    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      set_base(phase_idx < 7 ? plan[phase_idx] : BASE_W'($urandom_range(0, 36)));
      quiet = (phase_idx % 4) == 3;
      phase_end = chars_sent + CHARS_PER_PHASE;
      while (chars_sent < phase_end) begin
        send_random_string();
        if ($urandom_range(0, 19) == 0) drain_results();
      end
      phase_idx++;
    end
    quiet = 1'b0;
  endtask

  task automatic check_result();
    conv_result_t want;
    if (pending_results.size() == 0) begin
      error_count++;
      $display("%0t: result expected none got value %0d offset %0d status %0d", $time,
               $signed(u_out_if.value), u_out_if.end_offset, u_out_if.status);
    end else begin
      want = pending_results.pop_front();
      if (u_out_if.value !== want.value) begin
        error_count++;
        $display("%0t: value expected %0d got %0d", $time, want.value,
                 $signed(u_out_if.value));
      end
      if (u_out_if.end_offset !== want.end_offset) begin
        error_count++;
        $display("%0t: end_offset expected %0d got %0d", $time, want.end_offset,
                 u_out_if.end_offset);
      end
      if (u_out_if.status !== want.status) begin
        error_count++;
        $display("%0t: status expected %0d got %0d", $time, want.status, u_out_if.status);
      end
    end
  endtask

  initial begin
    int stall;
    u_out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        u_out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      u_out_if.ready <= 1'b1;
      @(posedge clk);
      while (!u_out_if.valid) @(posedge clk);
      check_result();
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    u_in_if.valid <= 1'b0;
    u_in_if.ch    <= CH_NUL;
    u_in_if.first <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= ADDR_NUMBER_BASE;
    pwdata        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_base_decimal();
    test_auto_base_prefixes();
    test_invalid_base();
    test_negative_overflow();
    test_random_mix();
    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ttsi_pkg.sv
rtl/ttsi_in_if.sv
rtl/ttsi_out_if.sv
rtl/text_to_signed_integer.sv
tb/text_to_signed_integer_test.sv
